FILE: rtl/core/csv_fs_pkg.sv
// Package for the CSV field splitter: result kinds, character codes and the
// result record type. Depends on nothing; used by every module of the block.
package csv_fs_pkg;

  typedef enum logic [1:0] {
    KIND_CONTENT    = 2'd0,
    KIND_FIELD_END  = 2'd1,
    KIND_RECORD_END = 2'd2
  } kind_e;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic [7:0] field_number;
  } result_t;

endpackage

FILE: rtl/core/csv_fs_parser.sv
// Quote state machine and field counter of the CSV field splitter.
// Depends on csv_fs_pkg; decides each accepted request combinationally.
module csv_fs_parser
  import csv_fs_pkg::*;
#(
  parameter int FIELD_INDEX_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] in_byte_i,
  input  logic       line_end_i,
  output logic       emit_o,
  output result_t    result_o
);

  localparam int WideBits = (FIELD_INDEX_BITS > 8) ? FIELD_INDEX_BITS : 8;
  localparam logic [FIELD_INDEX_BITS-1:0] IndexMax = '1;

  logic                        in_quoted_q, in_quoted_d;
  logic                        quote_pending_q, quote_pending_d;
  logic                        record_done_q, record_done_d;
  logic [FIELD_INDEX_BITS-1:0] field_index_q, field_index_d;
  logic [WideBits-1:0]         index_wide;
  logic [7:0]                  shown;
  logic                        plain;
  kind_e                       kind;
  logic [7:0]                  content;

  always_comb begin
    index_wide = WideBits'(field_index_q);
    if (index_wide > WideBits'(255)) begin
      shown = 8'hFF;
    end else begin
      shown = index_wide[7:0];
    end
  end

  always_comb begin
    in_quoted_d     = in_quoted_q;
    quote_pending_d = quote_pending_q;
    record_done_d   = record_done_q;
    field_index_d   = field_index_q;
    emit_o          = 1'b0;
    kind            = KIND_CONTENT;
    content         = in_byte_i;
    plain           = 1'b0;
    if (line_end_i) begin
      emit_o          = !record_done_q;
      kind            = KIND_RECORD_END;
      in_quoted_d     = 1'b0;
      quote_pending_d = 1'b0;
      record_done_d   = 1'b0;
      field_index_d   = '0;
    end else if (!record_done_q) begin
      if (quote_pending_q) begin
        quote_pending_d = 1'b0;
        if (in_byte_i == CH_QUOTE) begin
          emit_o = 1'b1;
        end else begin
          in_quoted_d = 1'b0;
          plain       = 1'b1;
        end
      end else if (in_quoted_q) begin
        if (in_byte_i == CH_QUOTE) begin
          quote_pending_d = 1'b1;
        end else if (in_byte_i != CH_CR && in_byte_i != CH_LF) begin
          emit_o = 1'b1;
        end
      end else begin
        plain = 1'b1;
      end
    end
    if (plain) begin
      if (in_byte_i == CH_QUOTE) begin
        in_quoted_d = 1'b1;
      end else if (in_byte_i == CH_COMMA) begin
        emit_o = 1'b1;
        kind   = KIND_FIELD_END;
        if (field_index_q != IndexMax) begin
          field_index_d = field_index_q + 1'b1;
        end
      end else if (in_byte_i == CH_CR || in_byte_i == CH_LF) begin
        emit_o        = 1'b1;
        kind          = KIND_RECORD_END;
        record_done_d = 1'b1;
      end else begin
        emit_o = 1'b1;
      end
    end
    result_o.kind         = kind;
    result_o.out_byte     = (kind == KIND_CONTENT) ? content : 8'h00;
    result_o.field_number = shown;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quoted_q     <= 1'b0;
      quote_pending_q <= 1'b0;
      record_done_q   <= 1'b0;
      field_index_q   <= '0;
    end else if (fire_i) begin
      in_quoted_q     <= in_quoted_d;
      quote_pending_q <= quote_pending_d;
      record_done_q   <= record_done_d;
      field_index_q   <= field_index_d;
    end
  end

endmodule

FILE: rtl/core/csv_fs_outbuf.sv
// Result register with a skid entry for the CSV field splitter.
// Depends on csv_fs_pkg; lets a new request enter while a result waits.
module csv_fs_outbuf
  import csv_fs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    stall_i,
  output result_t data_o
);

  logic    main_v_q, skid_v_q;
  result_t main_q, skid_q;
  logic    pop;

  assign pop     = main_v_q && !stall_i;
  assign valid_o = main_v_q;
  assign data_o  = main_q;
  assign full_o  = skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (push_i) begin
      if (main_v_q && !pop) begin
        skid_v_q <= 1'b1;
      end else begin
        main_v_q <= 1'b1;
      end
    end else if (pop) begin
      main_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (main_v_q && !pop) begin
        skid_q <= data_i;
      end else begin
        main_q <= data_i;
      end
    end
  end

endmodule

FILE: rtl/core/csv_field_splitter_unit.sv
// Top level of the CSV field splitter: parser state machine feeding a
// result register with skid entry. Depends on csv_fs_pkg and both submodules.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o | in_byte_i, line_end_i
//   out     | output    | out_valid_o/out_stall_i | kind_o, out_byte_o, field_number_o
//
// One request is taken every cycle unless in_stall_o is high; its result, if any,
// is registered. The rate is set by the quote state update in the parser.
// Reset clears the quote state, the field counter and the result buffer.
// A stalled output fills the skid entry, after which the input is stalled.
module csv_field_splitter_unit
  import csv_fs_pkg::*;
#(
  parameter int FIELD_INDEX_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       line_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic [7:0] field_number_o
);

  logic    fire;
  logic    emit;
  logic    full;
  result_t result;
  result_t out_data;

  assign in_stall_o = full;
  assign fire       = in_valid_i && !in_stall_o;

  csv_fs_parser #(
    .FIELD_INDEX_BITS(FIELD_INDEX_BITS)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .in_byte_i (in_byte_i),
    .line_end_i(line_end_i),
    .emit_o    (emit),
    .result_o  (result)
  );

  csv_fs_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fire && emit),
    .data_i (result),
    .full_o (full),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .data_o (out_data)
  );

  assign kind_o         = out_data.kind;
  assign out_byte_o     = out_data.out_byte;
  assign field_number_o = out_data.field_number;

  a_stall_needs_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !(fire && emit))
    else $error("result pushed into a full buffer");

  a_skid_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full && !out_stall_i) |=> !full)
    else $error("skid entry not drained after output request");

  a_byte_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_CONTENT) |-> (out_byte_o == 8'h00))
    else $error("non-content result carries a byte");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for csv_field_splitter_unit: a clocked driver and monitor,
// with a predictor of the quote and field state kept alongside the block.
// Depends on csv_fs_pkg and the RTL of csv_field_splitter_unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csv_fs_pkg::*;

  localparam int FIELD_BITS  = 8;
  localparam int HOLD_CYCLES = 120;
  localparam int ITEM_TARGET = 1600;

  typedef struct packed {
    logic       eol;
    logic [7:0] data;
  } line_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       line_end_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] kind_o;
  logic [7:0] out_byte_o;
  logic [7:0] field_number_o;

  line_item_t line_q[$];
  result_t    expected_q[$];

  logic                  in_quoted;
  logic                  quote_wait;
  logic                  rec_done;
  logic [FIELD_BITS-1:0] field_idx;

  int send_idle_pct = 36;
  int stall_pct = 36;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int items_made = 0;
  int requests_taken = 0;
  int results_seen = 0;
  int err_count = 0;

  csv_field_splitter_unit #(
    .FIELD_INDEX_BITS(FIELD_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .line_end_i    (line_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .out_byte_o    (out_byte_o),
    .field_number_o(field_number_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic result_t make_result(input kind_e kind, input logic [7:0] data);
    result_t res;
    res.kind         = kind;
    res.out_byte     = (kind == KIND_CONTENT) ? data : 8'h00;
    res.field_number = (field_idx > 255) ? 8'hFF : 8'(field_idx);
    return res;
  endfunction

  function automatic bit split_step(input logic [7:0] ch, input logic eol,
                                    output result_t res);
    bit hit;
    hit = 1'b0;
    res = '0;
    if (eol) begin
      if (!rec_done) begin
        hit = 1'b1;
        res = make_result(KIND_RECORD_END, 8'h00);
      end
      in_quoted  = 1'b0;
      quote_wait = 1'b0;
      rec_done   = 1'b0;
      field_idx  = '0;
    end else if (rec_done) begin
      hit = 1'b0;
    end else if (quote_wait && ch == CH_QUOTE) begin
      quote_wait = 1'b0;
      hit = 1'b1;
      res = make_result(KIND_CONTENT, CH_QUOTE);
    end else if (in_quoted && !quote_wait) begin
      if (ch == CH_QUOTE) begin
        quote_wait = 1'b1;
      end else if (ch != CH_CR && ch != CH_LF) begin
        hit = 1'b1;
        res = make_result(KIND_CONTENT, ch);
      end
    end else begin
      // Either plain unquoted text or a closing quote followed by this byte.
      quote_wait = 1'b0;
      in_quoted  = 1'b0;
      hit = 1'b1;
      if (ch == CH_QUOTE) begin
        in_quoted = 1'b1;
        hit = 1'b0;
      end else if (ch == CH_COMMA) begin
        res = make_result(KIND_FIELD_END, 8'h00);
        if (field_idx != {FIELD_BITS{1'b1}}) field_idx = field_idx + 1'b1;
      end else if (ch == CH_CR || ch == CH_LF) begin
        rec_done = 1'b1;
        res = make_result(KIND_RECORD_END, 8'h00);
      end else begin
        res = make_result(KIND_CONTENT, ch);
      end
    end
    return hit;
  endfunction

  always @(posedge clk_i) begin
    result_t res;
    bit      busy;
    line_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_quoted  = 1'b0;
      quote_wait = 1'b0;
      rec_done   = 1'b0;
      field_idx  = '0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        busy = 1'b0;
        requests_taken++;
        if (split_step(in_byte_i, line_end_i, res)) expected_q.push_back(res);
      end
      if (!busy) begin
        if (line_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = line_q.pop_front();
          in_valid_i <= 1'b1;
          in_byte_i  <= nxt.data;
          line_end_i <= nxt.eol;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_seen != hold_token) begin
      hold_seen   <= hold_token;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: kind %0d, out_byte %02h, field_number %0d",
               kind_o, out_byte_o, field_number_o);
        err_count++;
      end else begin
        want = expected_q.pop_front();
        results_seen++;
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          err_count++;
        end
        if (out_byte_o !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_byte_o);
          err_count++;
        end
        if (field_number_o !== want.field_number) begin
          $error("field_number: expected %0d, got %0d", want.field_number, field_number_o);
          err_count++;
        end
      end
    end
  end

  task automatic push_char(input logic [7:0] ch);
    line_q.push_back('{eol: 1'b0, data: ch});
    items_made++;
  endtask

  task automatic push_eol();
    line_q.push_back('{eol: 1'b1, data: 8'($urandom)});
    items_made++;
  endtask

  function automatic logic [7:0] special_char();
    case ($urandom_range(3))
      0: return CH_QUOTE;
      1: return CH_COMMA;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] ch;
    do ch = 8'($urandom);
    while (ch == CH_QUOTE || ch == CH_COMMA || ch == CH_CR || ch == CH_LF);
    return ch;
  endfunction

  task automatic push_record();
    int         n_fields;
    int         n_chars;
    logic [7:0] ch;
    n_fields = $urandom_range(1, 6);
    for (int f = 0; f < n_fields; f++) begin
      if (f != 0) push_char(CH_COMMA);
      n_chars = $urandom_range(0, 6);
      if ($urandom_range(1) == 1) begin
        push_char(CH_QUOTE);
        for (int k = 0; k < n_chars; k++) begin
          ch = ($urandom_range(3) == 0) ? special_char() : 8'($urandom);
          push_char(ch);
          if (ch == CH_QUOTE) push_char(CH_QUOTE);
        end
        push_char(CH_QUOTE);
      end else begin
        for (int k = 0; k < n_chars; k++) push_char(plain_char());
      end
    end
    case ($urandom_range(3))
      1: push_char(CH_CR);
      2: push_char(CH_LF);
      3: begin
        push_char(CH_CR);
        push_char(CH_LF);
        repeat ($urandom_range(0, 3)) push_char(8'($urandom));
      end
      default: ;
    endcase
    push_eol();
  endtask

  task automatic push_noise();
    repeat ($urandom_range(1, 16)) begin
      push_char(($urandom_range(1) == 0) ? special_char() : 8'($urandom));
    end
    push_eol();
  endtask

  task automatic push_wide_record(input int n_commas);
    for (int k = 0; k < n_commas; k++) begin
      if ($urandom_range(7) == 0) push_char(plain_char());
      push_char(CH_COMMA);
    end
    push_char(plain_char());
    if ($urandom_range(1) == 1) push_char(CH_LF);
    push_eol();
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (line_q.size() != 0 || in_valid_i || expected_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    push_char(8'h00);
    push_char(8'hFF);
    push_char(CH_COMMA);
    push_char(CH_QUOTE);
    push_char(CH_COMMA);
    push_char(CH_CR);
    push_char(CH_QUOTE);
    push_char(CH_QUOTE);
    push_char(CH_QUOTE);
    push_char(CH_COMMA);
    push_char(CH_QUOTE);
    push_char(CH_QUOTE);
    push_char(CH_LF);
    push_char("z");
    push_eol();
    push_char(CH_QUOTE);
    push_char(CH_LF);
    push_eol();
    push_char(CH_QUOTE);
    push_char(CH_QUOTE);
    push_eol();
    push_char("q");
    push_char(CH_CR);
    push_eol();
    push_eol();
    drain();

    send_idle_pct = 0;
    while (line_q.size() < 150) push_record();
    hold_token = hold_token + 1;
    drain();

    send_idle_pct = 0;
    stall_pct = 0;
    repeat (30) push_record();
    drain();

    send_idle_pct = 36;
    stall_pct = 36;
    push_wide_record(270);
    push_wide_record(260);
    drain();

    while (items_made < ITEM_TARGET) begin
      if ($urandom_range(4) == 0) push_noise();
      else push_record();
      if (line_q.size() > 64) begin
        while (line_q.size() > 16) @(negedge clk_i);
      end
    end
    drain();
    repeat (8) @(negedge clk_i);

    $display("Checked %0d results from %0d requests: quoted fields, doubled quotes,",
             results_seen, requests_taken);
    $display("line ends inside quotes, discarded tails, noise and field number saturation.");
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (expected_q.size() != 0) $error("%0d expected results never arrived", expected_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding.", expected_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: csv_field_splitter_unit.f
rtl/core/csv_fs_pkg.sv
rtl/core/csv_fs_parser.sv
rtl/core/csv_fs_outbuf.sv
rtl/core/csv_field_splitter_unit.sv
verif/tb.sv
